>>> hw/rtl/spi_master_register_block_defines.svh
// Assertion macros used by the SPI register block RTL.
`ifndef SPI_MASTER_REGISTER_BLOCK_DEFINES_SVH
`define SPI_MASTER_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SMRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("SPI register block assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SMRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("SPI register block assertion failed");

`endif

>>> hw/rtl/smrb_pkg.sv
// Types and constants of the SPI register block.
package smrb_pkg;

    localparam logic [11:0] OFF_CTRL1  = 12'd0;
    localparam logic [11:0] OFF_CTRL2  = 12'd4;
    localparam logic [11:0] OFF_STATUS = 12'd8;
    localparam logic [11:0] OFF_DATA   = 12'd12;
    localparam logic [11:0] OFF_CS     = 12'd16;

    localparam int ST_RXNE = 0;
    localparam int ST_TXE  = 1;
    localparam int ST_UDR  = 2;
    localparam int ST_OVR  = 3;

    localparam int C2_ERRIE  = 5;
    localparam int C2_RXNEIE = 6;
    localparam int C2_TXEIE  = 7;

    localparam logic [3:0] STATUS_RESET = 4'h2;
    localparam logic [7:0] DATA_RESET   = 8'h0C;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [11:0] offset;
        logic [31:0] write_data;
        logic [7:0]  miso_byte;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic [3:0]  cs_levels;
        logic [7:0]  mosi_byte;
        logic        mosi_valid;
        logic        bad_offset;
    } t_result;

endpackage

>>> hw/rtl/smrb_in_stage.sv
// Input register that captures one bus access word.
module smrb_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  smrb_pkg::t_access i_acc,
    output logic              o_valid,
    output smrb_pkg::t_access o_acc,
    input  logic              i_take
);
    import smrb_pkg::*;

    logic    r_valid;
    t_access r_acc;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_acc   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc <= i_acc;
        end
    end

endmodule

>>> hw/rtl/smrb_regfile.sv
// Register file and access decode of the SPI register block.
module smrb_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  smrb_pkg::t_access i_acc,
    output smrb_pkg::t_result o_res
);
    import smrb_pkg::*;

    `include "spi_master_register_block_defines.svh"

    logic [31:0] r_ctrl1, n_ctrl1;
    logic [31:0] r_ctrl2, n_ctrl2;
    logic [3:0]  r_status, n_status;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_cs, n_cs;
    t_result     res;
    logic        wr;

    assign wr = (i_acc.mode == MODE_WRITE);

    always_comb begin
        n_ctrl1  = r_ctrl1;
        n_ctrl2  = r_ctrl2;
        n_status = r_status;
        n_data   = r_data;
        n_cs     = r_cs;
        res      = '0;
        case (i_acc.offset)
            OFF_CTRL1: begin
                if (wr) begin
                    n_ctrl1 = i_acc.write_data;
                end else begin
                    res.read_data = r_ctrl1;
                end
            end
            OFF_CTRL2: begin
                if (wr) begin
                    n_ctrl2 = i_acc.write_data;
                end else begin
                    res.read_data = r_ctrl2;
                end
            end
            OFF_STATUS: begin
                if (wr) begin
                    if (i_acc.write_data[ST_UDR] || i_acc.write_data[ST_OVR]) begin
                        n_status[ST_UDR] = 1'b0;
                        n_status[ST_OVR] = 1'b0;
                    end
                end else begin
                    res.read_data = {28'd0, r_status};
                end
            end
            OFF_DATA: begin
                if (wr) begin
                    if (r_status[ST_RXNE]) begin
                        n_data           = i_acc.write_data[7:0];
                        n_status[ST_OVR] = 1'b1;
                    end else begin
                        res.mosi_byte     = i_acc.write_data[7:0];
                        res.mosi_valid    = 1'b1;
                        n_data            = i_acc.miso_byte;
                        n_status[ST_RXNE] = 1'b1;
                        n_status[ST_TXE]  = 1'b1;
                    end
                end else begin
                    if (r_status[ST_RXNE]) begin
                        n_status[ST_RXNE] = 1'b0;
                    end else begin
                        n_status[ST_UDR] = 1'b1;
                    end
                    res.read_data = {24'd0, r_data};
                end
            end
            OFF_CS: begin
                if (wr) begin
                    n_cs = i_acc.write_data[7:0];
                end else begin
                    res.read_data = {24'd0, r_cs};
                end
            end
            default: begin
                res.bad_offset = 1'b1;
            end
        endcase
        res.irq_level = (n_ctrl2[C2_TXEIE] && n_status[ST_TXE])
                     || (n_ctrl2[C2_RXNEIE] && n_status[ST_RXNE])
                     || (n_ctrl2[C2_ERRIE] && (n_status[ST_UDR] || n_status[ST_OVR]));
        res.cs_levels = ~(n_cs[3:0] & n_cs[7:4]);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1  <= '0;
            r_ctrl2  <= '0;
            r_status <= STATUS_RESET;
            r_data   <= DATA_RESET;
            r_cs     <= '0;
        end else if (i_fire) begin
            r_ctrl1  <= n_ctrl1;
            r_ctrl2  <= n_ctrl2;
            r_status <= n_status;
            r_data   <= n_data;
            r_cs     <= n_cs;
        end
    end

    // Nothing ever clears the transmit-empty flag.
    `SMRB_ASSERT_IMPL(a_txe_set, 1'b1, r_status[ST_TXE])
    `SMRB_ASSERT_NEXT(a_rxne_after_xfer, i_fire && res.mosi_valid, r_status[ST_RXNE])
    `SMRB_ASSERT_IMPL(a_xfer_on_data_write, res.mosi_valid, wr && (i_acc.offset == OFF_DATA))
    `SMRB_ASSERT_IMPL(a_bad_reads_zero, res.bad_offset, res.read_data == 32'd0)

endmodule

>>> hw/rtl/smrb_out_stage.sv
// Result register that holds one finished word until it is taken.
module smrb_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  smrb_pkg::t_result i_res,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output smrb_pkg::t_result o_res
);
    import smrb_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hw/rtl/spi_master_register_block.sv
// Top level of the SPI register block: input register, register file, result register.
// A word in the input register moves into the result register once the result register can load.
// Throughput: one word per cycle while results are taken; the register file updates as a word moves
// from the input register into the result register.
// Reset is synchronous and active low; it empties both stages and sets the
// registers to their reset values (status holds transmit empty, data holds 0x0C).
module spi_master_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [11:0] i_offset,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_miso_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_level,
    output logic [3:0]  o_cs_levels,
    output logic [7:0]  o_mosi_byte,
    output logic        o_mosi_valid,
    output logic        o_bad_offset
);
    import smrb_pkg::*;

    t_access in_acc;
    t_access acc;
    t_result res;
    t_result out_res;
    logic    acc_valid;
    logic    can_load;
    logic    take;

    assign in_acc.mode       = i_mode;
    assign in_acc.offset     = i_offset;
    assign in_acc.write_data = i_write_data;
    assign in_acc.miso_byte  = i_miso_byte;

    assign take = acc_valid && can_load;

    smrb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_acc   (in_acc),
        .o_valid (acc_valid),
        .o_acc   (acc),
        .i_take  (take)
    );

    smrb_regfile u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take),
        .i_acc   (acc),
        .o_res   (res)
    );

    smrb_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_read_data  = out_res.read_data;
    assign o_irq_level  = out_res.irq_level;
    assign o_cs_levels  = out_res.cs_levels;
    assign o_mosi_byte  = out_res.mosi_byte;
    assign o_mosi_valid = out_res.mosi_valid;
    assign o_bad_offset = out_res.bad_offset;

endmodule

>>> tb/spi_master_register_block_tb.sv
// Self-checking testbench for the SPI register block with a queue-fed driver and a monitor.
`timescale 1ns / 1ps

module spi_master_register_block_tb;
    import smrb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [11:0] i_offset = '0;
    logic [31:0] i_write_data = '0;
    logic [7:0]  i_miso_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_read_data;
    logic        o_irq_level;
    logic [3:0]  o_cs_levels;
    logic [7:0]  o_mosi_byte;
    logic        o_mosi_valid;
    logic        o_bad_offset;

    spi_master_register_block DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .i_miso_byte  (i_miso_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_irq_level  (o_irq_level),
        .o_cs_levels  (o_cs_levels),
        .o_mosi_byte  (o_mosi_byte),
        .o_mosi_valid (o_mosi_valid),
        .o_bad_offset (o_bad_offset)
    );

    t_access     pending_words[$];
    t_result     expected_results[$];

    logic [31:0] ctl_one;
    logic [31:0] ctl_two;
    logic [3:0]  stat;
    logic [7:0]  dbyte;
    logic [7:0]  cs_ctrl;

    int phase = 0;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_fail = 0;
    int n_exchanges = 0;
    int n_overruns = 0;
    int n_underruns = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit word_taken = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result spi_regs_access(t_access a);
        t_result r;
        r = '0;
        if (a.mode == MODE_WRITE) begin
            case (a.offset)
                OFF_CTRL1:  ctl_one = a.write_data;
                OFF_CTRL2:  ctl_two = a.write_data;
                OFF_STATUS: begin
                    if (a.write_data[ST_UDR] || a.write_data[ST_OVR]) begin
                        stat[ST_UDR] = 1'b0;
                        stat[ST_OVR] = 1'b0;
                    end
                end
                OFF_DATA: begin
                    dbyte = a.write_data[7:0];
                    if (stat[ST_RXNE]) begin
                        stat[ST_OVR] = 1'b1;
                        n_overruns++;
                    end else begin
                        r.mosi_byte  = dbyte;
                        r.mosi_valid = 1'b1;
                        dbyte = a.miso_byte;
                        stat[ST_RXNE] = 1'b1;
                        stat[ST_TXE]  = 1'b1;
                        n_exchanges++;
                    end
                end
                OFF_CS:     cs_ctrl = a.write_data[7:0];
                default:    r.bad_offset = 1'b1;
            endcase
        end else begin
            case (a.offset)
                OFF_CTRL1:  r.read_data = ctl_one;
                OFF_CTRL2:  r.read_data = ctl_two;
                OFF_STATUS: r.read_data = {28'b0, stat};
                OFF_DATA: begin
                    if (stat[ST_RXNE]) begin
                        stat[ST_RXNE] = 1'b0;
                    end else begin
                        stat[ST_UDR] = 1'b1;
                        n_underruns++;
                    end
                    r.read_data = {24'b0, dbyte};
                end
                OFF_CS:     r.read_data = {24'b0, cs_ctrl};
                default:    r.bad_offset = 1'b1;
            endcase
        end
        r.irq_level = (ctl_two[C2_TXEIE] & stat[ST_TXE])
                    | (ctl_two[C2_RXNEIE] & stat[ST_RXNE])
                    | (ctl_two[C2_ERRIE] & (stat[ST_UDR] | stat[ST_OVR]));
        for (int i = 0; i < 4; i++) begin
            r.cs_levels[i] = !(cs_ctrl[i] && cs_ctrl[i + 4]);
        end
        return r;
    endfunction

    always @(negedge i_clk) begin : drive
        t_access nxt;
        logic    nxt_valid;
        int      idle_pct;
        nxt = '0;
        nxt_valid = i_valid;
        idle_pct = (phase == 1) ? 62 : (phase == 3) ? 24 : 0;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || word_taken) begin
            nxt_valid = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_words.pop_front();
                nxt_valid = 1'b1;
                i_mode       <= nxt.mode;
                i_offset     <= nxt.offset;
                i_write_data <= nxt.write_data;
                i_miso_byte  <= nxt.miso_byte;
            end
        end
        i_valid <= nxt_valid;
    end

    always @(negedge i_clk) begin : receive
        int stall_pct;
        stall_pct = (phase == 2) ? 62 : (phase == 3) ? 24 : 0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && phase == 0 && n_accepted >= 40) begin
            hold_cnt = 60;
            hold_done = 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_access acc;
        t_result exp_r;
        t_result got_r;
        if (!i_rst_n) begin
            ctl_one = '0;
            ctl_two = '0;
            stat    = STATUS_RESET;
            dbyte   = DATA_RESET;
            cs_ctrl = '0;
            word_taken <= 1'b0;
        end else begin
            word_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                acc.mode       = i_mode;
                acc.offset     = i_offset;
                acc.write_data = i_write_data;
                acc.miso_byte  = i_miso_byte;
                expected_results.push_back(spi_regs_access(acc));
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                got_r.read_data  = o_read_data;
                got_r.irq_level  = o_irq_level;
                got_r.cs_levels  = o_cs_levels;
                got_r.mosi_byte  = o_mosi_byte;
                got_r.mosi_valid = o_mosi_valid;
                got_r.bad_offset = o_bad_offset;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display({"Unexpected result word: ",
                                  "rd=%h irq=%b cs=%h mosi=%h mv=%b bad=%b"},
                                 got_r.read_data, got_r.irq_level, got_r.cs_levels,
                                 got_r.mosi_byte, got_r.mosi_valid, got_r.bad_offset);
                    end
                end else begin
                    exp_r = expected_results.pop_front();
                    n_checked++;
                    if (got_r.read_data !== exp_r.read_data
                            || got_r.irq_level !== exp_r.irq_level
                            || got_r.cs_levels !== exp_r.cs_levels
                            || got_r.mosi_byte !== exp_r.mosi_byte
                            || got_r.mosi_valid !== exp_r.mosi_valid
                            || got_r.bad_offset !== exp_r.bad_offset) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display({"Mismatch on result %0d: expected ",
                                      "rd=%h irq=%b cs=%h mosi=%h mv=%b bad=%b"},
                                     n_checked, exp_r.read_data, exp_r.irq_level,
                                     exp_r.cs_levels, exp_r.mosi_byte, exp_r.mosi_valid,
                                     exp_r.bad_offset);
                            $display("    actual rd=%h irq=%b cs=%h mosi=%h mv=%b bad=%b",
                                     got_r.read_data, got_r.irq_level, got_r.cs_levels,
                                     got_r.mosi_byte, got_r.mosi_valid, got_r.bad_offset);
                        end
                    end
                end
            end
        end
    end

    task automatic push_word(logic m, logic [11:0] off, logic [31:0] wd, logic [7:0] miso);
        t_access a;
        a.mode       = m;
        a.offset     = off;
        a.write_data = wd;
        a.miso_byte  = miso;
        pending_words.push_back(a);
        n_pushed++;
    endtask

    initial begin : stimulus
        int          phase_order[5];
        logic [11:0] off;
        logic [31:0] wd;
        phase_order = '{0, 1, 2, 3, 0};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_word(MODE_READ,  OFF_CTRL1,  32'h0,        8'h00);
        push_word(MODE_READ,  OFF_CTRL2,  32'hFFFFFFFF, 8'hFF);
        push_word(MODE_READ,  OFF_STATUS, 32'h0,        8'h00);
        push_word(MODE_READ,  OFF_CS,     32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_CTRL1,  32'hFFFFFFFF, 8'h00);
        push_word(MODE_READ,  OFF_CTRL1,  32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_CTRL2,  32'h000000E0, 8'h00);
        push_word(MODE_READ,  OFF_DATA,   32'h0,        8'h00);
        push_word(MODE_READ,  OFF_STATUS, 32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_STATUS, 32'h00000004, 8'h00);
        push_word(MODE_WRITE, OFF_DATA,   32'h000000A5, 8'h3C);
        push_word(MODE_WRITE, OFF_DATA,   32'hFFFFFF5A, 8'hFF);
        push_word(MODE_READ,  OFF_STATUS, 32'h0,        8'h00);
        push_word(MODE_READ,  OFF_DATA,   32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_STATUS, 32'h00000008, 8'h00);
        push_word(MODE_WRITE, OFF_CS,     32'h000000FF, 8'h00);
        push_word(MODE_READ,  OFF_CS,     32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_CS,     32'hFFFFFF0F, 8'h00);
        push_word(MODE_WRITE, OFF_CTRL2,  32'h0,        8'h00);
        push_word(MODE_READ,  12'hFFF,    32'h0,        8'h00);
        push_word(MODE_WRITE, 12'h003,    32'hFFFFFFFF, 8'hFF);
        push_word(MODE_READ,  12'h014,    32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_CTRL1,  32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_DATA,   32'h0,        8'h00);
        push_word(MODE_WRITE, OFF_STATUS, 32'h00000003, 8'h00);

        foreach (phase_order[p]) begin
            while (pending_words.size() > 0) @(posedge i_clk);
            phase = phase_order[p];
            for (int n = 0; n < 350; n++) begin
                if ($urandom_range(99) < 15) begin
                    off = 12'($urandom_range(4095));
                end else begin
                    case ($urandom_range(9))
                        0:          off = OFF_CTRL1;
                        1:          off = OFF_CTRL2;
                        2, 3:       off = OFF_STATUS;
                        4, 5, 6, 7: off = OFF_DATA;
                        default:    off = OFF_CS;
                    endcase
                end
                wd = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom;
                push_word(1'($urandom_range(1)), off, wd, 8'($urandom_range(255)));
            end
        end

        while (n_accepted != n_pushed || expected_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (expected_results.size() != 0) n_fail++;
        $display("Covered %0d bus words and %0d checked results across four handshake modes.",
                 n_accepted, n_checked);
        $display("Saw %0d exchanges, %0d overruns and %0d underruns; %0d failures.",
                 n_exchanges, n_overruns, n_underruns, n_fail);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
